FILE: src/nmea_time_date_extractor_top_assert.svh
// Assertion macros shared by the extractor modules.
`ifndef NMEA_TIME_DATE_EXTRACTOR_TOP_ASSERT_SVH
`define NMEA_TIME_DATE_EXTRACTOR_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define NTE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define NTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/nte_pkg.sv
package nte_pkg;

   typedef logic [7:0] byte_type;

   localparam int SENTENCE_BOUND_DEFAULT = 128;
   localparam int HEADER_LEN             = 6;
   localparam int DIGIT_COUNT            = 6;
   localparam int GGA_TIME_FIRST         = 7;
   localparam int RMC_DATE_FIRST         = 53;
   localparam int RMC_LAT_POS            = 30;
   localparam int RMC_LON_POS            = 44;

   localparam logic [4:0]  ZONE_OFFSET_RESET = 5'd8;
   localparam logic [11:0] YEAR_BASE         = 12'd2000;
   localparam int          HOURS_PER_DAY     = 24;
   localparam int          MONTHS_PER_YEAR   = 12;
   localparam int          RECIP_24          = 171;
   localparam int          RECIP_SHIFT       = 12;

   localparam byte_type ASCII_DOLLAR = 8'h24;
   localparam byte_type ASCII_LF     = 8'h0A;
   localparam byte_type ASCII_ZERO   = 8'h30;

   localparam logic [39:0] TAG_GGA = "GPGGA";
   localparam logic [39:0] TAG_RMC = "GPRMC";
   localparam logic [39:0] TAG_GLL = "GPGLL";

   localparam byte_type MONTH_FEB = 8'd2;
   localparam byte_type MONTH_APR = 8'd4;
   localparam byte_type MONTH_JUN = 8'd6;
   localparam byte_type MONTH_SEP = 8'd9;
   localparam byte_type MONTH_NOV = 8'd11;

   // Two-digit years within 2000..2255 that are century years but not leap.
   localparam byte_type YEAR_CENTURY_A = 8'd100;
   localparam byte_type YEAR_CENTURY_B = 8'd200;

   typedef struct packed {
      byte_type gmt_hour;
      byte_type utc_minute;
      byte_type utc_second;
      byte_type gmt_year;
      byte_type gmt_month;
      byte_type utc_day;
      byte_type lat_hemisphere;
      byte_type lon_hemisphere;
   } rec_type;

   typedef struct packed {
      rec_type     utc;
      byte_type    local_hour;
      byte_type    local_day;
      byte_type    local_month;
      logic [11:0] local_year;
   } out_type;

   function automatic byte_type two_digits(input byte_type hi, input byte_type lo);
      byte_type h;
      byte_type l;
      h = hi - ASCII_ZERO;
      l = lo - ASCII_ZERO;
      return byte_type'({h, 3'b000} + {h, 1'b0} + l);
   endfunction

   function automatic logic [4:0] month_days(input byte_type month, input byte_type yr);
      logic leap;
      logic [4:0] days;
      leap = (yr[1:0] == 2'b00) && (yr != YEAR_CENTURY_A) && (yr != YEAR_CENTURY_B);
      case (month) inside
         MONTH_FEB:                                  days = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
         default:                                    days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

FILE: src/nmea_time_date_extractor_top.sv
// Channel  | Handshake           | Payload
// req      | req_valid/req_stall | req_rx_byte
// rsp      | rsp_valid/rsp_stall | rsp_utc_*, rsp_gmt_*, rsp_local_*, rsp_*_hemisphere
// csr      | csr_valid/csr_ready | csr_zone_offset_hours
//
// One byte per cycle while req_stall is low; a taken GLL newline yields a record.
// Path: input byte register, sentence capture into the record register, local time into
// the output register; the local-hour wrap uses a constant reciprocal multiply.
// Reset is synchronous; it clears capture state but the input byte, and sets the offset to 8.
// rsp_stall backs up through the three registers to req_stall only when all of them hold data.
`include "nmea_time_date_extractor_top_assert.svh"

module nmea_time_date_extractor_top #(
   parameter int SentenceBound = nte_pkg::SENTENCE_BOUND_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nte_pkg::byte_type req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nte_pkg::byte_type rsp_gmt_hour,
   output nte_pkg::byte_type rsp_utc_minute,
   output nte_pkg::byte_type rsp_utc_second,
   output nte_pkg::byte_type rsp_gmt_year,
   output nte_pkg::byte_type rsp_gmt_month,
   output nte_pkg::byte_type rsp_utc_day,
   output nte_pkg::byte_type rsp_local_hour,
   output nte_pkg::byte_type rsp_local_day,
   output nte_pkg::byte_type rsp_local_month,
   output logic [11:0]       rsp_local_year,
   output nte_pkg::byte_type rsp_lat_hemisphere,
   output nte_pkg::byte_type rsp_lon_hemisphere,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_zone_offset_hours
);
   import nte_pkg::*;

   logic [4:0] zone_offset_ff, zone_offset_in;
   logic       rec_valid;
   logic       rec_adv;
   rec_type    rec;
   out_type    out_data;

   assign csr_ready      = 1'b1;
   assign zone_offset_in = (csr_valid && csr_ready) ? csr_zone_offset_hours : zone_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_offset_ff <= ZONE_OFFSET_RESET;
      end else begin
         zone_offset_ff <= zone_offset_in;
      end
   end

   nte_parser #(
      .SentenceBound(SentenceBound)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_rx_byte(req_rx_byte),
      .rec_valid  (rec_valid),
      .rec_adv    (rec_adv),
      .rec        (rec)
   );

   nte_calendar u_calendar (
      .clock      (clock),
      .reset      (reset),
      .rec_valid  (rec_valid),
      .rec_adv    (rec_adv),
      .rec        (rec),
      .zone_offset(zone_offset_ff),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (out_data)
   );

   assign rsp_gmt_hour       = out_data.utc.gmt_hour;
   assign rsp_utc_minute     = out_data.utc.utc_minute;
   assign rsp_utc_second     = out_data.utc.utc_second;
   assign rsp_gmt_year       = out_data.utc.gmt_year;
   assign rsp_gmt_month      = out_data.utc.gmt_month;
   assign rsp_utc_day        = out_data.utc.utc_day;
   assign rsp_local_hour     = out_data.local_hour;
   assign rsp_local_day      = out_data.local_day;
   assign rsp_local_month    = out_data.local_month;
   assign rsp_local_year     = out_data.local_year;
   assign rsp_lat_hemisphere = out_data.utc.lat_hemisphere;
   assign rsp_lon_hemisphere = out_data.utc.lon_hemisphere;

   `NTE_ASSERT_NOW(a_local_hour_range, clock, reset, rsp_valid, rsp_local_hour < 8'(HOURS_PER_DAY), "local hour not below 24")
   `NTE_ASSERT_NOW(a_local_year_carry, clock, reset, rsp_valid, (rsp_local_year == YEAR_BASE + {4'b0, rsp_gmt_year}) || (rsp_local_year == YEAR_BASE + {4'b0, rsp_gmt_year} + 12'd1), "local year off by more than one")

endmodule

FILE: src/nte_parser.sv
`include "nmea_time_date_extractor_top_assert.svh"

module nte_parser #(
   parameter int SentenceBound = nte_pkg::SENTENCE_BOUND_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nte_pkg::byte_type req_rx_byte,
   output logic              rec_valid,
   input  logic              rec_adv,
   output nte_pkg::rec_type  rec
);
   import nte_pkg::*;

   logic     byte_valid_ff, byte_valid_in;
   byte_type byte_ff, byte_in;
   logic [7:0] pos_ff, pos_in;
   byte_type header_ff [HEADER_LEN];
   byte_type header_in [HEADER_LEN];
   byte_type gga_ff [DIGIT_COUNT];
   byte_type gga_in [DIGIT_COUNT];
   byte_type rmc_ff [DIGIT_COUNT];
   byte_type rmc_in [DIGIT_COUNT];
   byte_type lat_cap_ff, lat_cap_in;
   byte_type lon_cap_ff, lon_cap_in;
   logic     gga_done_ff, gga_done_in;
   logic     rmc_done_ff, rmc_done_in;
   rec_type  rec_ff, rec_in;
   logic     rec_valid_ff, rec_valid_in;

   logic       s2_adv;
   logic       s1_adv;
   logic       consume;
   logic [7:0] pos_eff;
   logic       hdr_dollar;
   logic [39:0] hdr_tag;
   logic       is_gga;
   logic       is_rmc;
   logic       is_gll;
   logic       is_lf;
   logic       in_header;
   logic       is_record;

   assign s2_adv    = !rec_valid_ff || rec_adv;
   assign s1_adv    = !byte_valid_ff || s2_adv;
   assign consume   = byte_valid_ff && s2_adv;
   assign req_stall = !s1_adv;

   assign pos_eff    = (byte_ff == ASCII_DOLLAR) ? 8'd0 : pos_ff;
   assign in_header  = pos_eff < 8'(HEADER_LEN);
   assign hdr_dollar = header_ff[0] == ASCII_DOLLAR;
   assign hdr_tag    = {header_ff[1], header_ff[2], header_ff[3], header_ff[4], header_ff[5]};
   assign is_gga     = hdr_dollar && (hdr_tag == TAG_GGA);
   assign is_rmc     = hdr_dollar && (hdr_tag == TAG_RMC);
   assign is_gll     = hdr_dollar && (hdr_tag == TAG_GLL);
   assign is_lf      = byte_ff == ASCII_LF;
   assign is_record  = !in_header && !is_gga && !is_rmc && is_gll && is_lf;

   always_comb begin
      pos_in      = pos_ff;
      header_in   = header_ff;
      gga_in      = gga_ff;
      rmc_in      = rmc_ff;
      lat_cap_in  = lat_cap_ff;
      lon_cap_in  = lon_cap_ff;
      gga_done_in = gga_done_ff;
      rmc_done_in = rmc_done_ff;
      rec_in      = rec_ff;
      if (consume) begin
         if (in_header) begin
            header_in[pos_eff[2:0]] = byte_ff;
            pos_in = pos_eff + 8'd1;
         end else if (is_gga || is_rmc) begin
            if (pos_eff < 8'(SentenceBound)) begin
               for (int k = 0; k < DIGIT_COUNT; k++) begin
                  if (is_gga && pos_eff == 8'(GGA_TIME_FIRST + k)) begin
                     gga_in[k] = byte_ff;
                  end
                  if (is_rmc && pos_eff == 8'(RMC_DATE_FIRST + k)) begin
                     rmc_in[k] = byte_ff;
                  end
               end
               if (is_rmc && pos_eff == 8'(RMC_LAT_POS)) begin
                  lat_cap_in = byte_ff;
               end
               if (is_rmc && pos_eff == 8'(RMC_LON_POS)) begin
                  lon_cap_in = byte_ff;
               end
               if (is_lf) begin
                  if (is_gga) begin
                     gga_done_in = 1'b1;
                  end else begin
                     rmc_done_in = 1'b1;
                  end
               end else begin
                  pos_in = pos_eff + 8'd1;
               end
            end
         end else if (is_record) begin
            if (gga_done_ff) begin
               gga_done_in       = 1'b0;
               rec_in.gmt_hour   = two_digits(gga_ff[0], gga_ff[1]);
               rec_in.utc_minute = two_digits(gga_ff[2], gga_ff[3]);
               rec_in.utc_second = two_digits(gga_ff[4], gga_ff[5]);
            end
            if (rmc_done_ff) begin
               rmc_done_in           = 1'b0;
               rec_in.utc_day        = two_digits(rmc_ff[0], rmc_ff[1]);
               rec_in.gmt_month      = two_digits(rmc_ff[2], rmc_ff[3]);
               rec_in.gmt_year       = two_digits(rmc_ff[4], rmc_ff[5]);
               rec_in.lat_hemisphere = lat_cap_ff;
               rec_in.lon_hemisphere = lon_cap_ff;
            end
         end
      end
   end

   assign byte_valid_in = s1_adv ? req_valid : byte_valid_ff;
   assign byte_in       = (s1_adv && req_valid) ? req_rx_byte : byte_ff;
   assign rec_valid_in  = s2_adv ? (consume && is_record) : rec_valid_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         byte_valid_ff <= 1'b0;
         pos_ff        <= '0;
         header_ff     <= '{default: '0};
         gga_ff        <= '{default: '0};
         rmc_ff        <= '{default: '0};
         lat_cap_ff    <= '0;
         lon_cap_ff    <= '0;
         gga_done_ff   <= 1'b0;
         rmc_done_ff   <= 1'b0;
         rec_ff        <= '0;
         rec_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         pos_ff        <= pos_in;
         header_ff     <= header_in;
         gga_ff        <= gga_in;
         rmc_ff        <= rmc_in;
         lat_cap_ff    <= lat_cap_in;
         lon_cap_ff    <= lon_cap_in;
         gga_done_ff   <= gga_done_in;
         rmc_done_ff   <= rmc_done_in;
         rec_ff        <= rec_in;
         rec_valid_ff  <= rec_valid_in;
      end
   end

   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

   `NTE_ASSERT_NOW(a_pos_bound, clock, reset, 1'b1, pos_ff <= 8'(SentenceBound), "position past bound")
   `NTE_ASSERT_NEXT(a_marks_cleared, clock, reset, consume && is_record, !gga_done_ff && !rmc_done_ff, "record left a done mark set")
   `NTE_ASSERT_NEXT(a_rec_only_on_record, clock, reset, s2_adv && !(consume && is_record), !rec_valid_ff, "record beat without GLL newline")

endmodule

FILE: src/nte_calendar.sv
module nte_calendar (
   input  logic             clock,
   input  logic             reset,
   input  logic             rec_valid,
   output logic             rec_adv,
   input  nte_pkg::rec_type rec,
   input  logic [4:0]       zone_offset,
   output logic             out_valid,
   input  logic             out_stall,
   output nte_pkg::out_type out_data
);
   import nte_pkg::*;

   logic    out_valid_ff, out_valid_in;
   out_type out_ff, out_in;

   logic [8:0]  hour_sum;
   logic [15:0] hour_prod;
   logic [3:0]  hour_quot;
   logic [8:0]  hour_rem;
   logic        day_wrap;
   logic [4:0]  mdays;
   logic [8:0]  day_next;
   logic [8:0]  month_next;
   logic        day_roll;
   logic        year_roll;

   assign rec_adv = !out_valid_ff || !out_stall;

   assign hour_sum   = {1'b0, rec.gmt_hour} + {4'b0, zone_offset};
   assign hour_prod  = 16'(hour_sum) * 16'(RECIP_24);
   assign hour_quot  = hour_prod[RECIP_SHIFT +: 4];
   assign hour_rem   = hour_sum - (9'({hour_quot, 4'b0000}) + 9'({hour_quot, 3'b000}));
   assign day_wrap   = hour_sum >= 9'(HOURS_PER_DAY);
   assign mdays      = month_days(rec.gmt_month, rec.gmt_year);
   assign day_next   = {1'b0, rec.utc_day} + 9'd1;
   assign month_next = {1'b0, rec.gmt_month} + 9'd1;
   assign day_roll   = day_wrap && (day_next > {4'b0, mdays});
   assign year_roll  = day_roll && (month_next > 9'(MONTHS_PER_YEAR));

   always_comb begin
      out_in.utc        = rec;
      out_in.local_hour = day_wrap ? hour_rem[7:0] : hour_sum[7:0];
      out_in.local_day  = !day_wrap ? rec.utc_day : (day_roll ? 8'd1 : day_next[7:0]);
      if (year_roll) begin
         out_in.local_month = 8'd1;
      end else if (day_roll) begin
         out_in.local_month = month_next[7:0];
      end else begin
         out_in.local_month = rec.gmt_month;
      end
      out_in.local_year = YEAR_BASE + {4'b0, rec.gmt_year} + {11'b0, year_roll};
   end

   assign out_valid_in = rec_adv ? rec_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (rec_adv && rec_valid) begin
         out_ff <= out_in;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule
